>>> rtl/core/crc8dfr_pkg.sv
// Shared types, register indexes and the CRC-8 byte update for the deframer.
package crc8dfr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 2'd2;

  localparam logic [7:0]  START_BYTE_RST    = 8'h55;
  localparam logic [5:0]  MAX_LENGTH_RST    = 6'd32;
  localparam logic [15:0] REPORT_PERIOD_RST = 16'd50;
  localparam logic [7:0]  CRC_POLY          = 8'h07;

  typedef struct packed {
    logic len_load;
    logic data_store;
    logic good_frame;
    logic bad_frame;
    logic rd_en;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    logic start_hit;
    logic len_ok;
    logic pos_last;
    logic crc_match;
    logic kind_err;
    logic rd_last;
  } sts_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc8dfr_ctrl.sv
// Frame parse and replay state machine.
module crc8dfr_ctrl
  import crc8dfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_line_error,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_LEN,
    S_DATA,
    S_CRC,
    S_RD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;
  logic   fire_ok;

  assign in_ready  = (state_r == S_HUNT) || (state_r == S_LEN) ||
                     (state_r == S_DATA) || (state_r == S_CRC);
  assign out_valid = (state_r == S_OUT);
  assign in_fire   = in_valid && in_ready;
  assign fire_ok   = in_fire && !in_line_error;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (fire_ok && sts.start_hit) state_nxt = S_LEN;
      end
      S_LEN: begin
        if (fire_ok) begin
          if (sts.len_ok) begin
            cmd.len_load = 1'b1;
            state_nxt    = S_DATA;
          end else begin
            state_nxt = S_HUNT;
          end
        end
      end
      S_DATA: begin
        if (fire_ok) begin
          cmd.data_store = 1'b1;
          if (sts.pos_last) state_nxt = S_CRC;
        end
      end
      S_CRC: begin
        if (fire_ok) begin
          if (sts.crc_match) begin
            cmd.good_frame = 1'b1;
            state_nxt      = S_RD;
          end else begin
            cmd.bad_frame = 1'b1;
            state_nxt     = S_OUT;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (sts.kind_err || sts.rd_last) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_RD;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
    if (in_fire && in_line_error) begin
      state_nxt = S_HUNT;
      cmd       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/crc8dfr_dp.sv
// Datapath: config registers, payload store, running CRC, counters and result registers.
module crc8dfr_dp
  import crc8dfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            in_byte_in,
  input  logic [31:0]           in_now_us,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_kind,
  output logic [7:0]            out_data_byte,
  output logic                  out_last_of_run,
  output logic [31:0]           out_frames_total,
  output logic [31:0]           out_crc_errors_total,
  output logic [31:0]           out_interval_us,
  output logic                  out_stats_due
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]       start_byte_r;
  logic [5:0]       max_length_r;
  logic [15:0]      report_period_r;
  logic [LEN_W-1:0] frame_length_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [7:0]       crc_r;
  logic [31:0]      frame_count_r;
  logic [31:0]      err_count_r;
  logic [31:0]      last_time_r;
  logic [31:0]      interval_r;
  logic [15:0]      countdown_r;
  logic             kind_r;
  logic             due_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [MAX_PAYLOAD];

  logic [7:0] limit;
  logic       count_expired;

  assign limit = ({2'b00, max_length_r} < 8'(MAX_PAYLOAD)) ? {2'b00, max_length_r}
                                                           : 8'(MAX_PAYLOAD);
  assign count_expired = (countdown_r <= 16'd1);

  assign sts.start_hit = (in_byte_in == start_byte_r);
  assign sts.len_ok    = (in_byte_in != 8'd0) && (in_byte_in <= limit);
  assign sts.pos_last  = (LEN_W'(pos_r) + LEN_W'(1)) == frame_length_r;
  assign sts.crc_match = (in_byte_in == crc_r);
  assign sts.kind_err  = kind_r;
  assign sts.rd_last   = (LEN_W'(rd_idx_r) + LEN_W'(1)) == frame_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= START_BYTE_RST;
      max_length_r    <= MAX_LENGTH_RST;
      report_period_r <= REPORT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:    start_byte_r    <= cfg_wdata[7:0];
        CFG_MAX_LENGTH:    max_length_r    <= cfg_wdata[5:0];
        CFG_REPORT_PERIOD: report_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= '0;
      pos_r          <= '0;
      rd_idx_r       <= '0;
      crc_r          <= '0;
      frame_count_r  <= '0;
      err_count_r    <= '0;
      last_time_r    <= '0;
      interval_r     <= '0;
      countdown_r    <= REPORT_PERIOD_RST;
      kind_r         <= 1'b0;
      due_r          <= 1'b0;
    end else begin
      if (cmd.len_load) begin
        frame_length_r <= LEN_W'(in_byte_in);
        pos_r          <= '0;
        crc_r          <= '0;
      end
      if (cmd.data_store) begin
        crc_r <= crc8_update(crc_r, in_byte_in);
        pos_r <= pos_r + IDX_W'(1);
      end
      if (cmd.good_frame) begin
        interval_r    <= in_now_us - last_time_r;
        last_time_r   <= in_now_us;
        frame_count_r <= frame_count_r + 32'd1;
        kind_r        <= 1'b0;
        due_r         <= count_expired;
        countdown_r   <= count_expired ? report_period_r : countdown_r - 16'd1;
        rd_idx_r      <= '0;
      end
      if (cmd.bad_frame) begin
        err_count_r <= err_count_r + 32'd1;
        kind_r      <= 1'b1;
        due_r       <= 1'b0;
      end
      if (cmd.rd_next) rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_store) mem[pos_r] <= in_byte_in;
    if (cmd.rd_en) rd_data_r <= mem[rd_idx_r];
  end

  assign out_kind             = kind_r;
  assign out_data_byte        = kind_r ? 8'd0 : rd_data_r;
  assign out_last_of_run      = kind_r || sts.rd_last;
  assign out_frames_total     = frame_count_r;
  assign out_crc_errors_total = err_count_r;
  assign out_interval_us      = interval_r;
  assign out_stats_due        = due_r;

endmodule

>>> rtl/core/crc8_length_framed_packet_receiver_core.sv
// Top level of the start/length/payload/CRC-8 frame receiver.
// Every input beat that causes no result is taken in the cycle it is offered.
// A good frame's CRC beat starts a replay of its payload, each byte read from the store, then
// held in the output register; a CRC error result shows in the cycle after its CRC beat.
// No input beat is taken while a replay or an error result is pending.
// Synchronous active-low reset: parser hunting, counters zero, registers at defaults.
module crc8_length_framed_packet_receiver_core
  import crc8dfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte_in,
  input  logic [31:0]           in_now_us,
  input  logic                  in_line_error,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_data_byte,
  output logic                  out_last_of_run,
  output logic [31:0]           out_frames_total,
  output logic [31:0]           out_crc_errors_total,
  output logic [31:0]           out_interval_us,
  output logic                  out_stats_due
);

  cmd_t cmd;
  sts_t sts;

  crc8dfr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_line_error(in_line_error),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  crc8dfr_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_byte_in          (in_byte_in),
    .in_now_us           (in_now_us),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_last_of_run     (out_last_of_run),
    .out_frames_total    (out_frames_total),
    .out_crc_errors_total(out_crc_errors_total),
    .out_interval_us     (out_interval_us),
    .out_stats_due       (out_stats_due)
  );

endmodule

>>> rtl/core/crc8dfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
module crc8dfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last_of_run,
  input logic       out_stats_due
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) && $stable(out_kind))
    else $error("result beat changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last_of_run && out_data_byte == 8'd0 && !out_stats_due)
    else $error("malformed CRC error result");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> !in_ready)
    else $error("input reopened before end of replay");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> in_ready && !out_valid)
    else $error("parser not back after last result");

endmodule

bind crc8_length_framed_packet_receiver_core crc8dfr_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_data_byte  (out_data_byte),
  .out_last_of_run(out_last_of_run),
  .out_stats_due  (out_stats_due)
);
